>>> rtl/core/dsp_pkg.sv
package dsp_pkg;

   localparam int SecWidth   = 31;
   localparam int NsWidth    = 30;
   localparam int CountWidth = 4;

   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   localparam logic [SecWidth-1:0] SecondsMax = 31'h7FFF_FFFF;
   localparam logic [NsWidth-1:0]  NsLimit    = 30'd1_000_000_000;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_CHAR   = 3'd1,
      ST_SECOND_SEP = 3'd2,
      ST_NO_INT     = 3'd3,
      ST_OVERFLOW   = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [SecWidth-1:0] seconds;
      logic [NsWidth-1:0]  nanoseconds;
      status_type          status;
   } result_type;

   // weight in nanoseconds of the fraction digit at a given place
   function automatic logic [NsWidth-1:0] place_scale(input logic [CountWidth-1:0] count);
      logic [NsWidth-1:0] scale;
      case (count)
         4'd0:    scale = 30'd100_000_000;
         4'd1:    scale = 30'd10_000_000;
         4'd2:    scale = 30'd1_000_000;
         4'd3:    scale = 30'd100_000;
         4'd4:    scale = 30'd10_000;
         4'd5:    scale = 30'd1_000;
         4'd6:    scale = 30'd100;
         4'd7:    scale = 30'd10;
         4'd8:    scale = 30'd1;
         default: scale = 30'd0;
      endcase
      return scale;
   endfunction

endpackage

>>> rtl/core/dsp_in_stage.sv
module dsp_in_stage
   import dsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic       req_last,
   input  logic       advance,
   output logic       item_valid,
   output item_type   item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     load;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
      if (load) begin
         item_in.character = req_character;
         item_in.last      = req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/core/dsp_accum.sv
module dsp_accum
   import dsp_pkg::*;
#(
   parameter int unsigned FRACTION_DIGITS = 9
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   localparam logic [CountWidth-1:0] FracLimit = CountWidth'(FRACTION_DIGITS);

   logic [SecWidth-1:0]   sec_ff, sec_in;
   logic [NsWidth-1:0]    frac_ff, frac_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  sep_ff, sep_in;
   logic                  int_seen_ff, int_seen_in;
   status_type            err_ff, err_in;

   logic                  is_sep;
   logic                  is_digit;
   logic                  text_err;
   logic [3:0]            digit;
   logic [SecWidth+3:0]   sec_wide;
   logic [NsWidth+3:0]    frac_term;
   status_type            status;

   always_comb begin
      is_sep   = (item.character == CharDot) || (item.character == CharComma);
      is_digit = item.character inside {[CharZero:CharNine]};
      text_err = (err_ff == ST_BAD_CHAR) || (err_ff == ST_SECOND_SEP);
      digit    = 4'(item.character - CharZero);
      sec_wide = ({4'd0, sec_ff} << 3) + ({4'd0, sec_ff} << 1) + {31'd0, digit};
      frac_term = {30'd0, digit} * {4'd0, place_scale(count_ff)};

      sec_in      = sec_ff;
      frac_in     = frac_ff;
      count_in    = count_ff;
      sep_in      = sep_ff;
      int_seen_in = int_seen_ff;
      err_in      = err_ff;

      if (is_sep) begin
         if (sep_ff && !text_err) begin
            err_in = ST_SECOND_SEP;
         end
         sep_in = 1'b1;
      end else if (!is_digit) begin
         if (!text_err) begin
            err_in = ST_BAD_CHAR;
         end
      end else if (sep_ff) begin
         if (count_ff < FracLimit) begin
            frac_in  = frac_ff + frac_term[NsWidth-1:0];
            count_in = count_ff + 4'd1;
         end
      end else begin
         int_seen_in = 1'b1;
         if (sec_wide[SecWidth+3:SecWidth] != 4'd0) begin
            sec_in = SecondsMax;
            if (err_ff == ST_OK) begin
               err_in = ST_OVERFLOW;
            end
         end else begin
            sec_in = sec_wide[SecWidth-1:0];
         end
      end

      status = err_in;
      if ((err_in == ST_OK) && !int_seen_in) begin
         status = ST_NO_INT;
      end
      result.status      = status;
      result.seconds     = (status == ST_OK) ? sec_in : '0;
      result.nanoseconds = (status == ST_OK) ? frac_in : '0;
   end

   // start over after the last character of a string
   always_ff @(posedge clock) begin
      if (reset || (fire && item.last)) begin
         sec_ff      <= '0;
         frac_ff     <= '0;
         count_ff    <= '0;
         sep_ff      <= 1'b0;
         int_seen_ff <= 1'b0;
         err_ff      <= ST_OK;
      end else if (fire) begin
         sec_ff      <= sec_in;
         frac_ff     <= frac_in;
         count_ff    <= count_in;
         sep_ff      <= sep_in;
         int_seen_ff <= int_seen_in;
         err_ff      <= err_in;
      end
   end

endmodule

>>> rtl/core/decimal_seconds_parser_core.sv
// a last character is held in the input stage register, then its result is registered
// in the output register and shown on rsp_valid; throughput is one character per cycle,
// limited by the single accumulator update, as long as rsp_stall does not hold a result
// while a result waits in out_ff, the input stage can hold one character, then req_stall
// reset (synchronous, active high) empties both stages and clears all accumulators
module decimal_seconds_parser_core
   import dsp_pkg::*;
#(
   parameter int unsigned FRACTION_DIGITS = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_character,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SecWidth-1:0] rsp_seconds,
   output logic [NsWidth-1:0]  rsp_nanoseconds,
   output logic [2:0]          rsp_status
);

   logic       advance;
   logic       item_valid;
   item_type   item;
   logic       fire;
   result_type result;
   result_type out_ff;
   logic       out_valid_ff;
   logic       out_valid_in;

   assign advance = !out_valid_ff || !rsp_stall;
   assign fire    = item_valid && advance;

   dsp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .req_last      (req_last),
      .advance       (advance),
      .item_valid    (item_valid),
      .item          (item)
   );

   dsp_accum #(
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_accum (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   assign out_valid_in = advance ? (fire && item.last) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && item.last) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_seconds     = out_ff.seconds;
   assign rsp_nanoseconds = out_ff.nanoseconds;
   assign rsp_status      = out_ff.status;

   a_err_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> ((rsp_seconds == '0) && (rsp_nanoseconds == '0)))
      else $error("error result carries a nonzero value");

   a_ns_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_nanoseconds < NsLimit))
      else $error("nanoseconds out of range");

   a_no_result_mid_string: assert property (@(posedge clock) disable iff (reset)
      (fire && !item.last) |=> !rsp_valid)
      else $error("result appeared for a character that is not last");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid && out_valid_ff && rsp_stall))
      else $error("input stalled without a held transfer");

endmodule
